// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_COPY  = 5'b01000,
      ST_FILL  = 5'b10000
   } state_type;

   // request modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // character and attribute codes
   localparam logic [7:0] NEWLINE_CODE = 8'h0A;
   localparam logic [7:0] SPACE_CODE   = 8'h20;
   localparam logic [7:0] RESET_ATTR   = 8'h07;

endpackage

// ===== rtl/core/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/text_console_cell_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Teletype-style text console: screen store of attribute/character cells
// in one RAM, cursor tracking, newline, line wrap and scroll-up.
// ----------------------------------------------------------------------------
// Latency: a write word gives its result at the accepting edge; a read word
// is read into the RAM output register there and answered from ST_READ; a
// scrolling write walks the RAM, ST_COPY then ST_FILL, before the next word.
// Throughput: one write per cycle at best; a read blocks words in ST_READ.
// Reset: a clearing pass writes every cell to a space with attribute 7;
// it and a scroll walk go one cell a cycle, while req_stall is held high.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_read_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_cell_value,
   output logic [4:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_column,
   output logic        rsp_did_scroll
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int RW         = $clog2(ROWS);
   localparam int CW         = $clog2(COLUMNS);
   localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;

   localparam logic [AW-1:0] LAST_CELL_A = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0] LAST_BASE_A = AW'(LAST_BASE);
   localparam logic [AW-1:0] COLUMNS_A   = AW'(COLUMNS);
   localparam logic [RW-1:0] LAST_ROW_R  = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL_C  = CW'(COLUMNS - 1);

   tcw_pkg::state_type state_ff, state_in;

   logic [AW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] base_ff, base_in;
   logic [7:0]    attr_ff;

   // staged write used by the copy and fill walks
   logic          wr_en_ff, wr_en_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic          wr_ram_ff, wr_ram_in;

   logic          rd_hit_ff, rd_hit_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_cell_ff;
   logic [4:0]    rsp_row_ff;
   logic [6:0]    rsp_col_ff;
   logic          rsp_scroll_ff;

   logic          rsp_load;
   logic [15:0]   rsp_cell_in;
   logic          rsp_scroll_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [15:0]   ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic [15:0]   ram_rdata;

   logic          accept;
   logic          idx_hit;
   logic [31:0]   idx_wide;
   logic [31:0]   row_wide;
   logic [31:0]   col_wide;
   logic          last_row;
   logic          last_col;

   assign req_stall = (state_ff != tcw_pkg::ST_IDLE) || wr_en_ff ||
                      (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign idx_wide  = 32'(req_read_index);
   assign idx_hit   = idx_wide < 32'(CELL_COUNT);
   assign last_row  = row_ff == LAST_ROW_R;
   assign last_col  = col_ff == LAST_COL_C;

   // screen store
   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequencer and cursor update
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      base_in       = base_ff;
      wr_en_in      = 1'b0;
      wr_addr_in    = wr_addr_ff;
      wr_ram_in     = wr_ram_ff;
      rd_hit_in     = rd_hit_ff;
      rsp_load      = 1'b0;
      rsp_cell_in   = 16'h0000;
      rsp_scroll_in = 1'b0;
      ram_we        = wr_en_ff;
      ram_waddr     = wr_addr_ff;
      ram_wdata     = wr_ram_ff ? ram_rdata : {attr_ff, tcw_pkg::SPACE_CODE};
      ram_re        = 1'b0;
      ram_raddr     = cnt_ff;

      unique case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE};
            if (cnt_ff == LAST_CELL_A) begin
               cnt_in   = '0;
               state_in = tcw_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode == tcw_pkg::MODE_READ) begin
                  ram_re    = idx_hit;
                  ram_raddr = idx_wide[AW-1:0];
                  rd_hit_in = idx_hit;
                  state_in  = tcw_pkg::ST_READ;
               end else begin
                  // store any byte but newline at the cursor
                  if (req_char_code != tcw_pkg::NEWLINE_CODE) begin
                     ram_we    = 1'b1;
                     ram_waddr = base_ff + AW'(col_ff);
                     ram_wdata = {attr_ff, req_char_code};
                  end
                  if (req_char_code != tcw_pkg::NEWLINE_CODE && !last_col) begin
                     col_in   = col_ff + CW'(1);
                     rsp_load = 1'b1;
                  end else if (!last_row) begin
                     col_in   = '0;
                     row_in   = row_ff + RW'(1);
                     base_in  = base_ff + COLUMNS_A;
                     rsp_load = 1'b1;
                  end else begin
                     // past the last row: start the scroll walk
                     col_in   = '0;
                     row_in   = LAST_ROW_R;
                     base_in  = LAST_BASE_A;
                     cnt_in   = COLUMNS_A;
                     state_in = tcw_pkg::ST_COPY;
                  end
               end
            end
         end
         tcw_pkg::ST_READ: begin
            rsp_load    = 1'b1;
            rsp_cell_in = rd_hit_ff ? ram_rdata : 16'h0000;
            state_in    = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_COPY: begin
            // read one row ahead, write the data back in the next cycle
            ram_re     = 1'b1;
            ram_raddr  = cnt_ff;
            wr_en_in   = 1'b1;
            wr_addr_in = cnt_ff - COLUMNS_A;
            wr_ram_in  = 1'b1;
            if (cnt_ff == LAST_CELL_A) begin
               cnt_in   = LAST_BASE_A;
               state_in = tcw_pkg::ST_FILL;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         tcw_pkg::ST_FILL: begin
            wr_en_in   = 1'b1;
            wr_addr_in = cnt_ff;
            wr_ram_in  = 1'b0;
            if (cnt_ff == LAST_CELL_A) begin
               cnt_in        = '0;
               rsp_load      = 1'b1;
               rsp_scroll_in = 1'b1;
               state_in      = tcw_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         default: begin
            state_in = tcw_pkg::ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   assign row_wide     = 32'(row_in);
   assign col_wide     = 32'(col_in);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         wr_en_ff     <= wr_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcw_pkg::RESET_ATTR;
      end else if (csr_write_enable) begin
         attr_ff <= csr_write_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      wr_ram_ff  <= wr_ram_in;
      rd_hit_ff  <= rd_hit_in;
      if (rsp_load) begin
         rsp_cell_ff   <= rsp_cell_in;
         rsp_row_ff    <= row_wide[4:0];
         rsp_col_ff    <= col_wide[6:0];
         rsp_scroll_ff <= rsp_scroll_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_value    = rsp_cell_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_did_scroll    = rsp_scroll_ff;

   // a word is only taken in the idle state with no staged write left
   assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == tcw_pkg::ST_IDLE) && !wr_en_ff)
      else $error("word accepted while the sequencer was busy");

   // cursor stays on the screen
   assert property (@(posedge clock) disable iff (reset)
      (row_ff <= LAST_ROW_R) && (col_ff <= LAST_COL_C))
      else $error("cursor left the screen");

   // row base tracks the cursor row
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != tcw_pkg::ST_CLEAR) |-> 32'(base_ff) == 32'(row_ff) * COLUMNS)
      else $error("row base out of step with cursor row");

   // copy writes trail the reads, so no row is overwritten before it is read
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_COPY) && wr_en_ff |-> wr_addr_ff < cnt_ff)
      else $error("scroll copy write overtook its read");

   // a scroll leaves the cursor at the start of the last row
   assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_scroll_in |=> (row_ff == LAST_ROW_R) && (col_ff == '0))
      else $error("scroll left the cursor off the last row start");

endmodule

// ===== dv/text_console_cell_writer_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer_tb
// Self-checking bench for the text console: drives write and read words,
// mirrors the screen store and cursor, and checks every result word in order.
// ----------------------------------------------------------------------------
module text_console_cell_writer_tb;

   localparam int COLUMNS      = 80;
   localparam int ROWS         = 25;
   localparam int CELLS        = ROWS * COLUMNS;
   // a scroll walks every cell before its result word goes out
   localparam int DRAIN_CYCLES = CELLS + 100;
   localparam int QUIET_LIMIT  = 20000;
   localparam int IDLE_PCT     = 18;

   typedef struct packed {
      logic [15:0] cell_value;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_column;
      logic        did_scroll;
   } console_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = tcw_pkg::MODE_WRITE;
   logic [7:0]  req_char_code = '0;
   logic [10:0] req_read_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_cell_value;
   logic [4:0]  rsp_cursor_row;
   logic [6:0]  rsp_cursor_column;
   logic        rsp_did_scroll;

   // mirror of the console
   logic [15:0]        screen_mirror [CELLS];
   int                 cur_row;
   int                 cur_col;
   logic [7:0]         text_attr;
   console_result_type pending_results [$];

   int fail_count  = 0;
   int quiet_cycles = 0;
   int words_sent  = 0;
   bit idling      = 1'b1;

   text_console_cell_writer #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_char_code    (req_char_code),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cell_value   (rsp_cell_value),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cursor_column(rsp_cursor_column),
      .rsp_did_scroll   (rsp_did_scroll)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // move the cursor to the next line, scrolling past the bottom row
   function automatic bit advance_row();
      int i;
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
         for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
            screen_mirror[i] = screen_mirror[i + COLUMNS];
         for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
            screen_mirror[i] = {text_attr, tcw_pkg::SPACE_CODE};
         cur_row = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // expected result word for one accepted request word
   function automatic console_result_type console_step(input logic mode,
                                                       input logic [7:0] ch,
                                                       input logic [10:0] idx);
      console_result_type r;
      int pos;
      r = '0;
      if (mode == tcw_pkg::MODE_READ) begin
         if (idx < CELLS) r.cell_value = screen_mirror[idx];
      end else if (ch == tcw_pkg::NEWLINE_CODE) begin
         r.did_scroll = advance_row();
      end else begin
         pos = cur_row * COLUMNS + cur_col;
         if (pos < CELLS) screen_mirror[pos] = {text_attr, ch};
         cur_col++;
         if (cur_col >= COLUMNS) r.did_scroll = advance_row();
      end
      r.cursor_row    = cur_row[4:0];
      r.cursor_column = cur_col[6:0];
      return r;
   endfunction

   // predict on accepted request words, check accepted result words
   always @(posedge clock) begin : monitor
      console_result_type want;
      int i;
      if (reset) begin
         for (i = 0; i < CELLS; i++)
            screen_mirror[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE};
         cur_row = 0;
         cur_col = 0;
         text_attr = tcw_pkg::RESET_ATTR;
         quiet_cycles = 0;
      end else begin
         if (csr_write_enable) text_attr = csr_write_data;
         if (req_valid && !req_stall)
            pending_results.push_back(console_step(req_mode, req_char_code, req_read_index));
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result word with no expectation waiting");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_cell_value !== want.cell_value) begin
                  $error("cell_value: expected %h, actual %h",
                         want.cell_value, rsp_cell_value);
                  fail_count++;
               end
               if (rsp_cursor_row !== want.cursor_row) begin
                  $error("cursor_row: expected %0d, actual %0d",
                         want.cursor_row, rsp_cursor_row);
                  fail_count++;
               end
               if (rsp_cursor_column !== want.cursor_column) begin
                  $error("cursor_column: expected %0d, actual %0d",
                         want.cursor_column, rsp_cursor_column);
                  fail_count++;
               end
               if (rsp_did_scroll !== want.did_scroll) begin
                  $error("did_scroll: expected %0d, actual %0d",
                         want.did_scroll, rsp_did_scroll);
                  fail_count++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_stall <= idling && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // no progress on either channel for too long
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   // present one request word and hold it until accepted
   task automatic send_word(input logic mode, input logic [7:0] ch, input logic [10:0] idx);
      @(negedge clock);
      while (idling && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_char_code  <= ch;
      req_read_index <= idx;
      do @(posedge clock); while (!(req_valid && !req_stall));
      words_sent++;
   endtask

   task automatic hold_requests();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // write the attribute register once the console has gone quiet
   task automatic set_attribute(input logic [7:0] value);
      hold_requests();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_char(input logic [7:0] ch);
      send_word(tcw_pkg::MODE_WRITE, ch, 11'($urandom_range(0, 2047)));
   endtask

   // read anywhere on the screen, on the cursor row, on the bottom row, or off the end
   task automatic send_read();
      int pick;
      logic [10:0] idx;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         idx = 11'($urandom_range(0, CELLS - 1));
      else if (pick < 75)
         idx = 11'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
      else if (pick < 90)
         idx = 11'((ROWS - 1) * COLUMNS + $urandom_range(0, COLUMNS - 1));
      else
         idx = 11'($urandom_range(CELLS, 2047));
      send_word(tcw_pkg::MODE_READ, 8'($urandom_range(0, 255)), idx);
   endtask

   // cells after reset, including indexes past the screen
   task automatic test_reset_fill();
      send_word(tcw_pkg::MODE_READ, 8'h00, 11'd0);
      send_word(tcw_pkg::MODE_READ, 8'hFF, 11'(CELLS - 1));
      send_word(tcw_pkg::MODE_READ, 8'h00, 11'(CELLS));
      send_word(tcw_pkg::MODE_READ, 8'hFF, 11'h7FF);
   endtask

   // byte extremes, newline, then read them back
   task automatic test_write_codes();
      send_word(tcw_pkg::MODE_WRITE, 8'h00, 11'h7FF);
      send_word(tcw_pkg::MODE_WRITE, 8'hFF, 11'h000);
      send_word(tcw_pkg::MODE_WRITE, 8'h41, 11'h555);
      send_word(tcw_pkg::MODE_WRITE, tcw_pkg::NEWLINE_CODE, 11'h2AA);
      send_word(tcw_pkg::MODE_READ, 8'h00, 11'd0);
      send_word(tcw_pkg::MODE_READ, 8'h00, 11'd1);
      send_word(tcw_pkg::MODE_READ, 8'h00, 11'd2);
      send_word(tcw_pkg::MODE_READ, 8'h00, 11'(COLUMNS));
   endtask

   // attribute register at both ends
   task automatic test_attribute_extremes();
      set_attribute(8'hFF);
      send_char(8'h5A);
      send_word(tcw_pkg::MODE_READ, 8'h00, 11'(COLUMNS));
      set_attribute(8'h00);
      send_char(8'h61);
      send_word(tcw_pkg::MODE_READ, 8'h00, 11'(COLUMNS + 1));
   endtask

   // text lines with random content, reads mixed in, some noise
   task automatic test_random_text(input logic [7:0] attr, input int n_words);
      int first;
      int pick;
      int len;
      int k;
      logic [7:0] ch;
      set_attribute(attr);
      first = words_sent;
      while (words_sent - first < n_words) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 170)
                                               : $urandom_range(0, 24);
            for (k = 0; k < len; k++) begin
               if ($urandom_range(0, 99) < 12) begin
                  send_read();
               end else begin
                  ch = 8'($urandom_range(0, 254));
                  if (ch >= tcw_pkg::NEWLINE_CODE) ch = ch + 8'd1;
                  send_char(ch);
               end
            end
            if ($urandom_range(0, 99) < 85) send_char(tcw_pkg::NEWLINE_CODE);
         end else if (pick < 82) begin
            repeat ($urandom_range(1, 6)) send_read();
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 5)) send_char(tcw_pkg::NEWLINE_CODE);
         end else begin
            repeat ($urandom_range(1, 8)) begin
               ch = ($urandom_range(0, 3) == 0) ? tcw_pkg::NEWLINE_CODE
                                                 : 8'($urandom_range(0, 255));
               send_word(1'($urandom_range(0, 1)), ch, 11'($urandom_range(0, 2047)));
            end
         end
      end
   endtask

   // same traffic with no idling on either side
   task automatic test_quiet_stretch(input logic [7:0] attr, input int n_words);
      idling = 1'b0;
      test_random_text(attr, n_words);
      idling = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_fill();
      test_write_codes();
      test_attribute_extremes();
      test_random_text(8'h00, 230);
      test_random_text(8'hFF, 230);
      test_quiet_stretch(8'($urandom_range(0, 255)), 230);
      test_random_text(tcw_pkg::RESET_ATTR, 230);
      test_random_text(8'($urandom_range(0, 255)), 230);
      test_random_text(8'($urandom_range(0, 255)), 230);

      // drain outstanding words and any scroll still walking
      hold_requests();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/text_console_cell_writer.sv
dv/text_console_cell_writer_tb.sv
